// ===== hw/rtl/a7ps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// a7ps_pkg: shared types, constants and helpers
// Widths, register indexes, the 8x8 pass map and dimension helpers.
// ----------------------------------------------------------------------------
package a7ps_pkg;

   localparam int DIM_MAX = 4096;           // largest width or height
   localparam int DIM_W   = 13;             // width of a dimension register
   localparam int CNT_W   = $clog2(DIM_MAX); // row and column counters
   localparam int OFS_W   = 24;             // pass offset width
   localparam int PASS_N  = 7;
   localparam int LVL_W   = 3;
   localparam int SLOT_W  = 3;
   localparam int PIX_W   = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;

   typedef logic [DIM_W-1:0] dim_type;
   typedef logic [OFS_W-1:0] ofs_type;
   typedef logic [PASS_N-1:0][OFS_W-1:0] base_vec_type;

   // status of the base calculator as seen by the top level
   typedef struct packed {
      logic         busy;
      base_vec_type base;
   } base_stat_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [LVL_W-1:0] lvl;
      ofs_type          ofs;
      logic             last;
   } result_type;

   localparam logic [LVL_W-1:0] PASS_MAP [8][8] = '{
      '{3'd1, 3'd6, 3'd4, 3'd6, 3'd2, 3'd6, 3'd4, 3'd6},
      '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7},
      '{3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6},
      '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7},
      '{3'd3, 3'd6, 3'd4, 3'd6, 3'd3, 3'd6, 3'd4, 3'd6},
      '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7},
      '{3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd6},
      '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7}
   };

   // zero reads as one, anything above the maximum reads as the maximum
   function automatic dim_type clamp_dim(input dim_type v);
      dim_type r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(DIM_MAX)) begin
         r = DIM_W'(DIM_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // count of indices below n that are congruent to k mod 8
   function automatic dim_type class_count(input dim_type n, input logic [2:0] k);
      logic [DIM_W:0] t;
      dim_type        r;
      t = {1'b0, n} - (DIM_W+1)'(k) + (DIM_W+1)'(7);
      if (n > DIM_W'(k)) begin
         r = DIM_W'(t >> 3);
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/adam7_pass_scatter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adam7_pass_scatter: Adam7 pass scatter for 8-bit grey pixels
// Tags each raster-order pixel with its Adam7 pass and its byte offset in
// the concatenated pass 1..7 data.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one grey pixel per word in raster order. rsp_* returns the
//   same pixel with its pass (rsp_tuser) and offset; rsp_tlast marks the
//   last pixel of the frame, after which all counters clear.
//   csr_* writes image width (index 0) or height (index 1). A write
//   restarts the frame and recomputes the pass bases; indexes beyond
//   these are ignored.
//   Throughput is one pixel per clock while req_tready is high. Each
//   accepted pixel is registered before it shows on rsp_tvalid.
//   After reset and after each register write the base sequencer runs a
//   setup step, then one shared multiply-accumulate step per pass;
//   req_tready stays low meanwhile.
//   A two-word output buffer decouples the sides: a stalled receiver costs
//   nothing until both words are full, then req_tready drops.
// ----------------------------------------------------------------------------
module adam7_pass_scatter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [a7ps_pkg::PIX_W-1:0]           req_tdata,  // [7:0] pixel_value
   // result stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [a7ps_pkg::PIX_W+a7ps_pkg::OFS_W-1:0] rsp_tdata, // [7:0] pixel_out,
                                                                 // [31:8] pass_offset
   output logic [a7ps_pkg::LVL_W-1:0]                rsp_tuser,  // [2:0] pass_level
   output logic                                      rsp_tlast,  // frame_end
   // register writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [a7ps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [a7ps_pkg::DIM_W-1:0]           csr_data
);

   a7ps_pkg::dim_type       width_ff, height_ff;
   logic                    csr_hit;
   a7ps_pkg::base_stat_type calc_stat;

   logic [a7ps_pkg::CNT_W-1:0] row_ff, col_ff;
   a7ps_pkg::ofs_type          fill_ff [a7ps_pkg::PASS_N];

   logic                           push, pop;
   logic [a7ps_pkg::LVL_W-1:0]     lvl;
   logic [a7ps_pkg::SLOT_W-1:0]    slot;
   logic                           last_col, last_row;
   a7ps_pkg::result_type           res_in;
   a7ps_pkg::result_type           out_ff, skid_ff;
   logic                           out_valid_ff, skid_valid_ff;

   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && csr_ready
                      && (csr_index == a7ps_pkg::CSR_WIDTH
                          || csr_index == a7ps_pkg::CSR_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= a7ps_pkg::DIM_W'(1);
         height_ff <= a7ps_pkg::DIM_W'(1);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == a7ps_pkg::CSR_WIDTH) begin
            width_ff <= a7ps_pkg::clamp_dim(csr_data);
         end else if (csr_index == a7ps_pkg::CSR_HEIGHT) begin
            height_ff <= a7ps_pkg::clamp_dim(csr_data);
         end
      end
   end

   a7ps_base_calc u_calc (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_hit),
      .width  (width_ff),
      .height (height_ff),
      .stat   (calc_stat)
   );

   assign req_tready = !calc_stat.busy && !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   assign lvl      = a7ps_pkg::PASS_MAP[row_ff[2:0]][col_ff[2:0]];
   assign slot     = lvl - a7ps_pkg::LVL_W'(1);
   assign last_col = ({1'b0, col_ff} + 1'b1) >= width_ff;
   assign last_row = ({1'b0, row_ff} + 1'b1) >= height_ff;

   always_comb begin
      res_in.pix  = req_tdata;
      res_in.lvl  = lvl;
      res_in.ofs  = calc_stat.base[slot] + fill_ff[slot];
      res_in.last = last_col && last_row;
   end

   // position and per-pass fill counters
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         row_ff <= '0;
         col_ff <= '0;
         for (int p = 0; p < a7ps_pkg::PASS_N; p++) begin
            fill_ff[p] <= '0;
         end
      end else if (push) begin
         if (res_in.last) begin
            row_ff <= '0;
            col_ff <= '0;
            for (int p = 0; p < a7ps_pkg::PASS_N; p++) begin
               fill_ff[p] <= '0;
            end
         end else begin
            fill_ff[slot] <= fill_ff[slot] + a7ps_pkg::OFS_W'(1);
            if (last_col) begin
               col_ff <= '0;
               row_ff <= row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
      end
   end

   // output word plus skid word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.ofs, out_ff.pix};
   assign rsp_tuser  = out_ff.lvl;
   assign rsp_tlast  = out_ff.last;

endmodule
`default_nettype wire

// ===== hw/rtl/a7ps_base_calc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// a7ps_base_calc: pass base sequencer
// Derives the sizes of passes 1..6 from width and height with one shared
// multiplier and accumulates them into the pass base offsets.
// ----------------------------------------------------------------------------
module a7ps_base_calc (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire a7ps_pkg::dim_type      width,
   input  wire a7ps_pkg::dim_type      height,
   output a7ps_pkg::base_stat_type     stat
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   localparam logic [2:0] LAST_STEP = 3'(a7ps_pkg::PASS_N - 1);

   logic [1:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;

   // row and column class sums
   a7ps_pkg::dim_type r0_ff, r4_ff, r04_ff, r26_ff, r0246_ff;
   a7ps_pkg::dim_type c0_ff, c4_ff, c04_ff, c26_ff, c0246_ff, c1357_ff;

   a7ps_pkg::ofs_type      prod_ff;
   a7ps_pkg::ofs_type      acc_ff;
   a7ps_pkg::base_vec_type base_ff;

   a7ps_pkg::dim_type fa, fb;
   logic [2*a7ps_pkg::DIM_W-1:0] prod_full;
   a7ps_pkg::ofs_type sum;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      if (start) begin
         state_in = ST_SETUP;
      end else begin
         case (state_ff)
            ST_SETUP: begin
               state_in = ST_RUN;
               step_in  = '0;
            end
            ST_RUN: begin
               if (step_ff == LAST_STEP) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SETUP;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // factors of pass n+1 size: row class sum times column class sum
   always_comb begin
      case (step_ff)
         3'd0: begin fa = r0_ff;    fb = c0_ff;    end
         3'd1: begin fa = r0_ff;    fb = c4_ff;    end
         3'd2: begin fa = r4_ff;    fb = c04_ff;   end
         3'd3: begin fa = r04_ff;   fb = c26_ff;   end
         3'd4: begin fa = r26_ff;   fb = c0246_ff; end
         3'd5: begin fa = r0246_ff; fb = c1357_ff; end
         default: begin fa = '0;    fb = '0;       end
      endcase
   end

   assign prod_full = fa * fb;
   assign sum       = acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_SETUP) begin
         r0_ff    <= a7ps_pkg::class_count(height, 3'd0);
         r4_ff    <= a7ps_pkg::class_count(height, 3'd4);
         r04_ff   <= a7ps_pkg::class_count(height, 3'd0)
                     + a7ps_pkg::class_count(height, 3'd4);
         r26_ff   <= a7ps_pkg::class_count(height, 3'd2)
                     + a7ps_pkg::class_count(height, 3'd6);
         r0246_ff <= a7ps_pkg::class_count(height, 3'd0)
                     + a7ps_pkg::class_count(height, 3'd2)
                     + a7ps_pkg::class_count(height, 3'd4)
                     + a7ps_pkg::class_count(height, 3'd6);
         c0_ff    <= a7ps_pkg::class_count(width, 3'd0);
         c4_ff    <= a7ps_pkg::class_count(width, 3'd4);
         c04_ff   <= a7ps_pkg::class_count(width, 3'd0)
                     + a7ps_pkg::class_count(width, 3'd4);
         c26_ff   <= a7ps_pkg::class_count(width, 3'd2)
                     + a7ps_pkg::class_count(width, 3'd6);
         c0246_ff <= a7ps_pkg::class_count(width, 3'd0)
                     + a7ps_pkg::class_count(width, 3'd2)
                     + a7ps_pkg::class_count(width, 3'd4)
                     + a7ps_pkg::class_count(width, 3'd6);
         c1357_ff <= a7ps_pkg::class_count(width, 3'd1)
                     + a7ps_pkg::class_count(width, 3'd3)
                     + a7ps_pkg::class_count(width, 3'd5)
                     + a7ps_pkg::class_count(width, 3'd7);
         acc_ff     <= '0;
         base_ff[0] <= '0;
      end else if (state_ff == ST_RUN) begin
         prod_ff <= prod_full[a7ps_pkg::OFS_W-1:0];
         // base of pass n+1 is the sum of all earlier pass sizes
         if (step_ff != 3'd0) begin
            acc_ff           <= sum;
            base_ff[step_ff] <= sum;
         end
      end
   end

   assign stat = {(state_ff != ST_IDLE), base_ff};

endmodule
`default_nettype wire

// ===== hw/rtl/a7ps_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// a7ps_checker: port-level checks for adam7_pass_scatter
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module a7ps_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_tready,
   input wire logic                                  rsp_tvalid,
   input wire logic                                  rsp_tready,
   input wire logic [a7ps_pkg::PIX_W+a7ps_pkg::OFS_W-1:0] rsp_tdata,
   input wire logic [a7ps_pkg::LVL_W-1:0]            rsp_tuser,
   input wire logic                                  rsp_tlast,
   input wire logic                                  csr_valid,
   input wire logic                                  csr_ready,
   input wire logic [a7ps_pkg::CSR_IDX_W-1:0]        csr_index
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // pass number is never zero
   a_pass_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != '0)
      else $error("pass level zero");

   // a register write recomputes bases, so input is held off next cycle
   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready
      && (csr_index == a7ps_pkg::CSR_WIDTH || csr_index == a7ps_pkg::CSR_HEIGHT)
      |=> !req_tready)
      else $error("input accepted during base recompute");

   // reset leaves no result and runs the base sequencer
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind adam7_pass_scatter a7ps_checker u_a7ps_checker (.*);
`default_nettype wire
